// ===== rtl/quic_header_byte_parser_assert.svh =====
// Assertion macros for the header parser checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef QUIC_HEADER_BYTE_PARSER_ASSERT_SVH
`define QUIC_HEADER_BYTE_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define QHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define QHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/qhp_pkg.sv =====
// Shared types and constants for the QUIC header byte parser.
// No dependencies; imported by every module of the block.
package qhp_pkg;

  // Byte classes double as parser phases
  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_VERSION = 3'd1,
    PH_IDLEN   = 3'd2,
    PH_DEST    = 3'd3,
    PH_SRC     = 3'd4,
    PH_PAYLEN  = 3'd5,
    PH_PKTNUM  = 3'd6,
    PH_BEYOND  = 3'd7
  } qhp_phase_t;

  localparam int QHP_QUEUE_DEPTH = 4;

  localparam logic [4:0] QHP_SHORT_ID_RESET = 5'd8;
  localparam logic [4:0] QHP_SHORT_ID_MAX   = 5'd20;
  localparam logic [2:0] QHP_VERSION_BYTES  = 3'd4;
  localparam logic [2:0] QHP_LONG_PN_BYTES  = 3'd4;
  localparam logic [4:0] QHP_ID_LEN_BIAS    = 5'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } qhp_in_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  echo_byte;
    logic        header_done;
    logic        long_form;
    logic [6:0]  packet_kind;
    logic        key_phase_bit;
    logic [31:0] version_word;
    logic [4:0]  dest_id_len;
    logic [4:0]  src_id_len;
    logic [61:0] payload_len;
    logic [31:0] pkt_number;
  } qhp_out_t;

  // Classified byte handed from the front to the back
  typedef struct packed {
    qhp_phase_t cls;
    logic [7:0] data;
    logic       pay_first;
    logic       done;
    logic       form;
    logic [4:0] dest_len;
    logic [4:0] src_len;
  } qhp_op_t;

endpackage

// ===== rtl/qhp_queue.sv =====
// Small FIFO of classified bytes between the parser front and back.
// Depends on qhp_pkg for the entry type.
module qhp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  qhp_pkg::qhp_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output qhp_pkg::qhp_op_t head_op
);
  import qhp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qhp_op_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/qhp_front.sv =====
// Parser front: tracks the header phase and classifies each byte.
// Depends on qhp_pkg; feeds qhp_queue with one op per accepted byte.
module qhp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [4:0]       cfg_wr_data,
  input  logic             take,
  input  qhp_pkg::qhp_in_t item,
  output qhp_pkg::qhp_op_t op
);
  import qhp_pkg::*;

  qhp_phase_t phase_r, phase_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       form_r, form_nxt;
  logic [4:0] dest_len_r, dest_len_nxt;
  logic [4:0] src_len_r, src_len_nxt;
  logic [3:0] vlen_r, vlen_nxt;
  logic [2:0] nlen_r, nlen_nxt;
  logic       vers_nz_r, vers_nz_nxt;
  logic [4:0] short_len_r;

  logic [7:0] b;
  logic [5:0] cnt_inc;
  logic [3:0] vlen_eff;
  logic       done;

  assign b       = item.data_byte;
  assign cnt_inc = {1'b0, cnt_r} + 6'd1;

  // Short-form destination ID length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_len_r <= QHP_SHORT_ID_RESET;
    end else if (cfg_wr_en) begin
      short_len_r <= cfg_wr_data;
    end
  end

  // Phase sequencing and byte classification
  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    form_nxt     = form_r;
    dest_len_nxt = dest_len_r;
    src_len_nxt  = src_len_r;
    vlen_nxt     = vlen_r;
    nlen_nxt     = nlen_r;
    vers_nz_nxt  = vers_nz_r;
    vlen_eff     = vlen_r;
    done         = 1'b0;
    op.cls       = PH_BEYOND;
    op.pay_first = 1'b0;

    if (item.packet_start) begin
      op.cls      = PH_FIRST;
      cnt_nxt     = '0;
      vlen_nxt    = '0;
      src_len_nxt = '0;
      nlen_nxt    = '0;
      vers_nz_nxt = 1'b0;
      if (b[7]) begin
        form_nxt     = 1'b1;
        dest_len_nxt = '0;
        phase_nxt    = PH_VERSION;
      end else begin
        form_nxt     = 1'b0;
        dest_len_nxt = (short_len_r > QHP_SHORT_ID_MAX) ? QHP_SHORT_ID_MAX : short_len_r;
        // Size code: 0 -> 1 byte, 1 -> 2, 2 -> 4, 3 -> none
        unique case (b[1:0])
          2'd0:    nlen_nxt = 3'd1;
          2'd1:    nlen_nxt = 3'd2;
          2'd2:    nlen_nxt = 3'd4;
          default: nlen_nxt = 3'd0;
        endcase
        if (dest_len_nxt != '0) begin
          phase_nxt = PH_DEST;
        end else if (nlen_nxt == '0) begin
          done = 1'b1;
        end else begin
          phase_nxt = PH_PKTNUM;
        end
      end
    end else begin
      op.cls = phase_r;
      unique case (phase_r)
        PH_VERSION: begin
          vers_nz_nxt = vers_nz_r | (|b);
          cnt_nxt     = cnt_inc[4:0];
          if (cnt_inc >= {3'd0, QHP_VERSION_BYTES}) begin
            cnt_nxt   = '0;
            phase_nxt = PH_IDLEN;
          end
        end
        PH_IDLEN: begin
          dest_len_nxt = {1'b0, b[7:4]} + QHP_ID_LEN_BIAS;
          src_len_nxt  = {1'b0, b[3:0]} + QHP_ID_LEN_BIAS;
          cnt_nxt      = '0;
          phase_nxt    = PH_DEST;
        end
        PH_DEST: begin
          cnt_nxt = cnt_inc[4:0];
          if (cnt_inc >= {1'b0, dest_len_r}) begin
            cnt_nxt = '0;
            if (form_r) begin
              phase_nxt = PH_SRC;
            end else if (nlen_r == '0) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_PKTNUM;
            end
          end
        end
        PH_SRC: begin
          cnt_nxt = cnt_inc[4:0];
          if (cnt_inc >= {1'b0, src_len_r}) begin
            cnt_nxt = '0;
            if (vers_nz_r) begin
              phase_nxt = PH_PAYLEN;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_PAYLEN: begin
          // First varint byte carries the length code in its top bits
          if (cnt_r == '0) begin
            op.pay_first = 1'b1;
            vlen_eff     = 4'd1 << b[7:6];
            vlen_nxt     = vlen_eff;
          end
          cnt_nxt = cnt_inc[4:0];
          if (cnt_inc >= {2'd0, vlen_eff}) begin
            cnt_nxt   = '0;
            nlen_nxt  = QHP_LONG_PN_BYTES;
            phase_nxt = PH_PKTNUM;
          end
        end
        PH_PKTNUM: begin
          cnt_nxt = cnt_inc[4:0];
          if (cnt_inc >= {3'd0, nlen_r}) begin
            done = 1'b1;
          end
        end
        default: begin
          op.cls = PH_BEYOND;
        end
      endcase
    end

    if (done) begin
      phase_nxt = PH_BEYOND;
      cnt_nxt   = '0;
    end

    op.data     = b;
    op.done     = done;
    op.form     = form_nxt;
    op.dest_len = dest_len_nxt;
    op.src_len  = src_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_BEYOND;
      cnt_r      <= '0;
      form_r     <= 1'b0;
      dest_len_r <= '0;
      src_len_r  <= '0;
      vlen_r     <= '0;
      nlen_r     <= '0;
      vers_nz_r  <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      form_r     <= form_nxt;
      dest_len_r <= dest_len_nxt;
      src_len_r  <= src_len_nxt;
      vlen_r     <= vlen_nxt;
      nlen_r     <= nlen_nxt;
      vers_nz_r  <= vers_nz_nxt;
    end
  end

endmodule

// ===== rtl/qhp_back.sv =====
// Parser back: accumulates header fields and drives the result register.
// Depends on qhp_pkg; pops classified bytes from qhp_queue.
module qhp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_valid,
  input  qhp_pkg::qhp_op_t  op,
  output logic              op_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output qhp_pkg::qhp_out_t out_item
);
  import qhp_pkg::*;

  logic [6:0]  type_r, type_nxt;
  logic        kp_r, kp_nxt;
  logic [31:0] ver_r, ver_nxt;
  logic [61:0] len_r, len_nxt;
  logic [31:0] num_r, num_nxt;
  logic        out_valid_r;
  qhp_out_t    out_item_r, out_item_nxt;
  logic        vneg;

  // Result register frees up when empty or being taken
  assign op_pop    = op_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Field accumulation
  always_comb begin
    type_nxt = type_r;
    kp_nxt   = kp_r;
    ver_nxt  = ver_r;
    len_nxt  = len_r;
    num_nxt  = num_r;
    unique case (op.cls)
      PH_FIRST: begin
        ver_nxt = '0;
        len_nxt = '0;
        num_nxt = '0;
        if (op.data[7]) begin
          type_nxt = op.data[6:0];
          kp_nxt   = 1'b0;
        end else begin
          type_nxt = '0;
          kp_nxt   = op.data[6];
        end
      end
      PH_VERSION: ver_nxt = {ver_r[23:0], op.data};
      PH_PAYLEN: begin
        if (op.pay_first) begin
          len_nxt = {56'd0, op.data[5:0]};
        end else begin
          len_nxt = {len_r[53:0], op.data};
        end
      end
      PH_PKTNUM: num_nxt = {num_r[23:0], op.data};
      default: begin
      end
    endcase
  end

  // Result assembly; decoded fields only on the last header byte
  always_comb begin
    vneg         = op.form && (ver_nxt == '0);
    out_item_nxt = '0;
    out_item_nxt.byte_class = op.cls;
    out_item_nxt.echo_byte  = op.data;
    if (op.done) begin
      out_item_nxt.header_done   = 1'b1;
      out_item_nxt.long_form     = op.form;
      out_item_nxt.packet_kind   = op.form ? type_nxt : '0;
      out_item_nxt.key_phase_bit = op.form ? 1'b0 : kp_nxt;
      out_item_nxt.version_word  = op.form ? ver_nxt : '0;
      out_item_nxt.dest_id_len   = op.dest_len;
      out_item_nxt.src_id_len    = op.form ? op.src_len : '0;
      out_item_nxt.payload_len   = (op.form && !vneg) ? len_nxt : '0;
      out_item_nxt.pkt_number    = vneg ? '0 : num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      type_r     <= type_nxt;
      kp_r       <= kp_nxt;
      ver_r      <= ver_nxt;
      len_r      <= len_nxt;
      num_r      <= num_nxt;
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/quic_header_byte_parser.sv =====
// Path: an accepted byte is classified by the front, pushed into the byte queue, then popped into the result register.
// Throughput: one byte per cycle while the queue is not full; the front's phase and byte-count update is combinational.
// The byte queue (Q_DEPTH entries) absorbs output stall; in_stall rises when it is full.
// Reset: synchronous, active-low rst_n; parser returns to the beyond-header phase,
// queue and result register empty, short ID length register back to 8.
module quic_header_byte_parser #(
  parameter int Q_DEPTH = qhp_pkg::QHP_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qhp_pkg::qhp_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output qhp_pkg::qhp_out_t out_item,
  input  logic              cfg_wr_en,
  input  logic [4:0]        cfg_wr_data
);
  import qhp_pkg::*;

  qhp_op_t front_op;
  qhp_op_t head_op;
  logic    q_full;
  logic    q_not_empty;
  logic    q_pop;
  logic    take;

  // Input side only waits on queue space
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  qhp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .take       (take),
    .item       (in_item),
    .op         (front_op)
  );

  qhp_queue #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .push_op  (front_op),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head_op  (head_op)
  );

  qhp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (q_not_empty),
    .op       (head_op),
    .op_pop   (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

// ===== rtl/qhp_checker.sv =====
// Port-level checks on the header parser's result channel.
// Depends on qhp_pkg and the assertion macro header; bound to the top level.
`include "quic_header_byte_parser_assert.svh"

module qhp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input qhp_pkg::qhp_out_t out_item
);
  import qhp_pkg::*;

  // A stalled result stays put
  `QHP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")

  // Decoded fields are zero away from the last header byte
  `QHP_ASSERT_NOW(a_idle_fields, out_valid && !out_item.header_done, out_item.long_form == 1'b0 && out_item.packet_kind == '0 && out_item.key_phase_bit == 1'b0 && out_item.version_word == '0 && out_item.dest_id_len == '0 && out_item.src_id_len == '0 && out_item.payload_len == '0 && out_item.pkt_number == '0, "header fields set on a non-final byte")

  // Short header reports no long-form fields and a clamped ID length
  `QHP_ASSERT_NOW(a_short_fields, out_valid && out_item.header_done && !out_item.long_form, out_item.packet_kind == '0 && out_item.version_word == '0 && out_item.src_id_len == '0 && out_item.payload_len == '0 && out_item.dest_id_len <= QHP_SHORT_ID_MAX, "short header fields inconsistent")

  // Long header: biased ID lengths, negotiation carries no length or number
  `QHP_ASSERT_NOW(a_long_fields, out_valid && out_item.header_done && out_item.long_form, out_item.key_phase_bit == 1'b0 && out_item.dest_id_len >= QHP_ID_LEN_BIAS && out_item.src_id_len >= QHP_ID_LEN_BIAS && (out_item.version_word != '0 || (out_item.payload_len == '0 && out_item.pkt_number == '0)), "long header fields inconsistent")

endmodule

bind quic_header_byte_parser qhp_checker u_qhp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);

// ===== verif/tb.sv =====
// Self-checking bench for quic_header_byte_parser: directed and random packet byte streams.
// An in-bench header decoder predicts the class and header report of every accepted byte.
// Depends on qhp_pkg and the parser RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qhp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_BYTES  = 305;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_TRIGGER = 400;

  // DUT connections; the inputs are known from time zero
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  qhp_in_t   in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  qhp_out_t  out_item;
  logic      cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;

  // Request and result bookkeeping
  qhp_in_t  pending[$];
  qhp_out_t byte_results[$];
  int queued_count = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int error_count = 0;
  int headers_long = 0;
  int headers_short = 0;
  int headers_neg = 0;
  int settings_used = 0;
  bit steady = 1'b0;

  // Decoder state, mirrors the block after reset
  logic [4:0]  short_id_len = QHP_SHORT_ID_RESET;
  qhp_phase_t  prs_phase = PH_BEYOND;
  logic [4:0]  prs_count = '0;
  logic        prs_long = 1'b0;
  logic [6:0]  prs_kind = '0;
  logic        prs_key = 1'b0;
  logic [31:0] prs_version = '0;
  logic [4:0]  prs_dest_len = '0;
  logic [4:0]  prs_src_len = '0;
  logic [3:0]  prs_varint_len = '0;
  logic [61:0] prs_length = '0;
  logic [2:0]  prs_pn_len = '0;
  logic [31:0] prs_pn = '0;

  quic_header_byte_parser uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Short form: move on to the packet number, or finish if it has no bytes
  function automatic logic enter_short_number();
    if (prs_pn_len == 3'd0) return 1'b1;
    prs_phase = PH_PKTNUM;
    prs_count = '0;
    return 1'b0;
  endfunction

  // Advance the header decoder by one byte and build the expected result
  function automatic qhp_out_t parse_byte(qhp_in_t req);
    qhp_out_t   res;
    qhp_phase_t cls;
    logic [7:0] b;
    logic       done;
    logic       vneg;
    b = req.data_byte;
    done = 1'b0;
    res = '0;
    if (req.packet_start) begin
      cls = PH_FIRST;
      prs_count = '0;
      prs_version = '0;
      prs_length = '0;
      prs_pn = '0;
      prs_varint_len = '0;
      prs_src_len = '0;
      prs_kind = '0;
      prs_key = 1'b0;
      prs_pn_len = '0;
      if (b[7]) begin
        prs_long = 1'b1;
        prs_kind = b[6:0];
        prs_dest_len = '0;
        prs_phase = PH_VERSION;
      end else begin
        prs_long = 1'b0;
        prs_key = b[6];
        // oversized register values clamp to the protocol maximum
        prs_dest_len = (short_id_len > QHP_SHORT_ID_MAX) ? QHP_SHORT_ID_MAX : short_id_len;
        case (b[1:0])
          2'd0: prs_pn_len = 3'd1;
          2'd1: prs_pn_len = 3'd2;
          2'd2: prs_pn_len = 3'd4;
          default: prs_pn_len = 3'd0;
        endcase
        if (prs_dest_len != '0) prs_phase = PH_DEST;
        else done = enter_short_number();
      end
    end else begin
      cls = prs_phase;
      case (prs_phase)
        PH_VERSION: begin
          prs_version = {prs_version[23:0], b};
          prs_count++;
          if (prs_count >= QHP_VERSION_BYTES) begin
            prs_count = '0;
            prs_phase = PH_IDLEN;
          end
        end
        PH_IDLEN: begin
          prs_dest_len = 5'(b[7:4]) + QHP_ID_LEN_BIAS;
          prs_src_len = 5'(b[3:0]) + QHP_ID_LEN_BIAS;
          prs_count = '0;
          prs_phase = PH_DEST;
        end
        PH_DEST: begin
          prs_count++;
          if (prs_count >= prs_dest_len) begin
            prs_count = '0;
            if (prs_long) prs_phase = PH_SRC;
            else done = enter_short_number();
          end
        end
        PH_SRC: begin
          prs_count++;
          if (prs_count >= prs_src_len) begin
            prs_count = '0;
            if (prs_version == '0) done = 1'b1;
            else prs_phase = PH_PAYLEN;
          end
        end
        PH_PAYLEN: begin
          // varint: top two bits of the first byte give its size
          if (prs_count == '0) begin
            prs_varint_len = 4'd1 << b[7:6];
            prs_length = 62'(b[5:0]);
          end else begin
            prs_length = {prs_length[53:0], b};
          end
          prs_count++;
          if (prs_count >= prs_varint_len) begin
            prs_count = '0;
            prs_pn_len = QHP_LONG_PN_BYTES;
            prs_pn = '0;
            prs_phase = PH_PKTNUM;
          end
        end
        PH_PKTNUM: begin
          prs_pn = {prs_pn[23:0], b};
          prs_count++;
          if (prs_count >= prs_pn_len) done = 1'b1;
        end
        default: cls = PH_BEYOND;
      endcase
    end

    if (done) begin
      prs_phase = PH_BEYOND;
      prs_count = '0;
    end

    res.byte_class = cls;
    res.echo_byte = b;
    if (done) begin
      vneg = prs_long && (prs_version == '0);
      res.header_done = 1'b1;
      res.long_form = prs_long;
      res.packet_kind = prs_long ? prs_kind : '0;
      res.key_phase_bit = prs_long ? 1'b0 : prs_key;
      res.version_word = prs_long ? prs_version : '0;
      res.dest_id_len = prs_dest_len;
      res.src_id_len = prs_long ? prs_src_len : '0;
      res.payload_len = (prs_long && !vneg) ? prs_length : '0;
      res.pkt_number = vneg ? '0 : prs_pn;
    end
    return res;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic start);
    qhp_in_t req;
    req.data_byte = b;
    req.packet_start = start;
    pending.push_back(req);
    queued_count++;
  endtask

  // ID length nibble: mostly short, sometimes the maximum
  function automatic logic [3:0] pick_nibble();
    case ($urandom_range(0, 3))
      0: return 4'hF;
      1: return 4'($urandom);
      default: return 4'($urandom_range(0, 2));
    endcase
  endfunction

  // One packet: well-formed header with random content, sometimes cut short,
  // sometimes followed by payload bytes; a few requests are pure noise
  task automatic queue_random_packet();
    logic [7:0] pkt[$];
    logic [7:0] lead_byte;
    logic [3:0] dn, sn;
    logic [1:0] vcode;
    int         sel, cut, id_len, pn_bytes;
    logic       neg, all_ones;
    sel = $urandom_range(0, 99);
    all_ones = ($urandom_range(0, 7) == 0);
    if (sel < 8) begin
      repeat ($urandom_range(1, 6)) queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    if (sel < 60) begin
      neg = (sel < 20);
      pkt.push_back({1'b1, 7'($urandom)});
      repeat (4) pkt.push_back(neg ? 8'h00 : 8'($urandom));
      dn = pick_nibble();
      sn = pick_nibble();
      pkt.push_back({dn, sn});
      repeat (int'(dn) + 3) pkt.push_back(8'($urandom));
      repeat (int'(sn) + 3) pkt.push_back(8'($urandom));
      if (!neg) begin
        vcode = 2'($urandom);
        pkt.push_back({vcode, all_ones ? 6'h3F : 6'($urandom)});
        repeat ((1 << vcode) - 1) pkt.push_back(all_ones ? 8'hFF : 8'($urandom));
        repeat (4) pkt.push_back(all_ones ? 8'hFF : 8'($urandom));
      end
    end else begin
      lead_byte = 8'($urandom) & 8'h7F;
      pkt.push_back(lead_byte);
      id_len = int'((short_id_len > QHP_SHORT_ID_MAX) ? QHP_SHORT_ID_MAX : short_id_len);
      repeat (id_len) pkt.push_back(8'($urandom));
      case (lead_byte[1:0])
        2'd0: pn_bytes = 1;
        2'd1: pn_bytes = 2;
        2'd2: pn_bytes = 4;
        default: pn_bytes = 0;
      endcase
      repeat (pn_bytes) pkt.push_back(all_ones ? 8'hFF : 8'($urandom));
    end
    cut = pkt.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, pkt.size());
    for (int i = 0; i < cut; i++) queue_byte(pkt[i], i == 0);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0);
  endtask

  // Block idle: every request taken, every result back, pipeline flushed
  task automatic wait_drained();
    while (accepted_count != queued_count || byte_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_short_id_len(input logic [4:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    short_id_len = value;
    settings_used++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Sender: presents queued requests, random idle bursts, holds payload while stalled
  always @(posedge clk) begin
    qhp_out_t res;
    int       send_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        res = parse_byte(in_item);
        byte_results.push_back(res);
        accepted_count++;
        if (res.header_done) begin
          if (!res.long_form) headers_short++;
          else if (res.version_word == '0) headers_neg++;
          else headers_long++;
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!steady && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_item <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: one long hold to fill the byte queue, then random bursts
  always @(posedge clk) begin
    int  hold_left;
    int  recv_gap;
    bit  hold_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      recv_gap = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result check against the oldest expected byte result
  always @(posedge clk) begin
    qhp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (byte_results.size() == 0) begin
        $error("result with no request outstanding: byte 0x%0h", out_item.echo_byte);
        error_count++;
      end else begin
        want = byte_results.pop_front();
        check_field("byte_class", 64'(want.byte_class), 64'(out_item.byte_class));
        check_field("echo_byte", 64'(want.echo_byte), 64'(out_item.echo_byte));
        check_field("header_done", 64'(want.header_done), 64'(out_item.header_done));
        check_field("long_form", 64'(want.long_form), 64'(out_item.long_form));
        check_field("packet_kind", 64'(want.packet_kind), 64'(out_item.packet_kind));
        check_field("key_phase_bit", 64'(want.key_phase_bit), 64'(out_item.key_phase_bit));
        check_field("version_word", 64'(want.version_word), 64'(out_item.version_word));
        check_field("dest_id_len", 64'(want.dest_id_len), 64'(out_item.dest_id_len));
        check_field("src_id_len", 64'(want.src_id_len), 64'(out_item.src_id_len));
        check_field("payload_len", 64'(want.payload_len), 64'(out_item.payload_len));
        check_field("pkt_number", 64'(want.pkt_number), 64'(out_item.pkt_number));
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int plan[5];
    plan = '{20, 31, 1, 8, -1};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero short ID length so short headers stay tiny
    write_short_id_len(5'd0);
    queue_byte(8'h00, 1'b0);            // bytes outside a header
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h43, 1'b1);            // empty short header, key phase set
    queue_byte(8'h3D, 1'b1);            // short, 2-byte number
    queue_byte(8'hAB, 1'b0);
    queue_byte(8'hCD, 1'b0);
    queue_byte(8'h3E, 1'b1);            // short, 4-byte number
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h81, 1'b1);            // long header cut by a new start
    queue_byte(8'h12, 1'b0);
    queue_byte(8'hFF, 1'b1);            // version negotiation, minimum IDs
    repeat (4) queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    repeat (3) queue_byte(8'hFF, 1'b0);
    repeat (3) queue_byte(8'h5A, 1'b0);
    wait_drained();

    // Random phases over several ID length settings; last phase runs without idling
    foreach (plan[p]) begin
      write_short_id_len(plan[p] < 0 ? 5'($urandom_range(0, 31)) : 5'(plan[p]));
      if (p == $size(plan) - 1) steady = 1'b1;
      begin
        int target;
        target = queued_count + PHASE_BYTES;
        while (queued_count < target) queue_random_packet();
      end
      wait_drained();
    end

    $display("Checked %0d bytes under %0d ID length settings", accepted_count, settings_used);
    $display("Headers reported: %0d long, %0d negotiation, %0d short",
             headers_long, headers_neg, headers_short);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
